// File: src/srs_pkg.sv
// Shared types and constants for the systematic resampler.
`timescale 1ns / 1ps
package srs_pkg;

	// default sizing handed to the top level
	localparam int MAX_PARTICLES_DEF = 64;
	localparam int WEIGHT_BITS_DEF   = 16;

	// particle_count after reset
	localparam logic [6:0] COUNT_RESET = 7'd64;

	// request kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// one input request
	typedef struct packed {
		logic        kind;
		logic [15:0] weight;
		logic [15:0] offset;
	} in_req_t;

	// one resampled slot
	typedef struct packed {
		logic [5:0] index;
		logic       last;
		logic       zero_sum;
	} out_res_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEED,
		BK_WALK
	} back_state_t;

endpackage

// File: src/systematic_resampler.sv
// Top level of the systematic resampler: front end, run queue, back end.
// A load request writes its scaled weight into memory; a start request passes through
// the run queue, the seed and walk states and the result register. A run of n indices
// moves the cursor at most n - 1 times in the single compare-and-add walk of the back
// end, which stalls on a full result register. New requests wait until a run ends.
// Reset: asynchronous, active low; clears counts, sum and queues; count resets to 64.
`timescale 1ns / 1ps
module systematic_resampler #(
	parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = srs_pkg::WEIGHT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  srs_pkg::in_req_t  item,
	output logic              empty,
	input  logic              pop,
	output srs_pkg::out_res_t result,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata
);
	import srs_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int CMD_W = 16 + WEIGHT_BITS + IDX_W + 2 * CNT_W;
	localparam int NW_W  = WEIGHT_BITS + CNT_W;

	logic             q_push;
	logic [CMD_W-1:0] q_wdata;
	logic             q_pop;
	logic             q_empty;
	logic [CMD_W-1:0] q_rdata;
	logic             back_busy;
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	logic [NW_W-1:0]  mem_wdata;

	srs_front #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_empty  (q_empty),
		.back_busy(back_busy),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata)
	);

	srs_cmd_queue #(
		.W(CMD_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.empty (q_empty),
		.rdata (q_rdata)
	);

	srs_back #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!q_empty),
		.cmd_data (q_rdata),
		.cmd_pop  (q_pop),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.busy     (back_busy),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

// File: src/srs_front.sv
// Front end: takes requests, stores scaled weights, queues resampling runs.
`timescale 1ns / 1ps
module srs_front #(
	parameter int MAX_PARTICLES = 64,
	parameter int WEIGHT_BITS   = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               push,
	output logic                                               full,
	input  srs_pkg::in_req_t                                   item,
	input  logic                                               cfg_we,
	input  logic [6:0]                                         cfg_wdata,
	input  logic                                               q_empty,
	input  logic                                               back_busy,
	output logic                                               q_push,
	output logic [16+WEIGHT_BITS+$clog2(MAX_PARTICLES)+2*$clog2(MAX_PARTICLES+1)-1:0] q_data,
	output logic                                               mem_we,
	output logic [$clog2(MAX_PARTICLES)-1:0]                   mem_addr,
	output logic [WEIGHT_BITS+$clog2(MAX_PARTICLES+1)-1:0]     mem_wdata
);
	import srs_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int SUM_W = WEIGHT_BITS + IDX_W;
	localparam int NW_W  = WEIGHT_BITS + CNT_W;

	logic [6:0]             pc_q;
	logic [CNT_W-1:0]       load_q;
	logic [SUM_W-1:0]       total_q;
	logic [CNT_W-1:0]       n;
	logic [WEIGHT_BITS-1:0] w;
	logic                   accept;
	logic                   do_load;

	// active particle count: saturate high, zero acts as one
	always_comb begin
		if (pc_q > 7'(MAX_PARTICLES)) begin
			n = CNT_W'(MAX_PARTICLES);
		end else if (pc_q == 7'd0) begin
			n = CNT_W'(1);
		end else begin
			n = pc_q[CNT_W-1:0];
		end
	end

	// hold off while a run is queued or still being worked off
	assign full    = !q_empty || back_busy;
	assign accept  = push && !full;
	assign w       = WEIGHT_BITS'(item.weight);
	assign do_load = accept && (item.kind == KIND_LOAD) && (load_q < n);

	// weights are stored pre-multiplied by n, so the back end only adds
	assign mem_we    = do_load;
	assign mem_addr  = load_q[IDX_W-1:0];
	assign mem_wdata = NW_W'(n) * NW_W'(w);

	// start request: snapshot of offset, sum, loaded count and n
	assign q_push = accept && (item.kind == KIND_START);
	assign q_data = {item.offset, total_q, load_q, n};

	// count register, load count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= COUNT_RESET;
			load_q  <= '0;
			total_q <= '0;
		end else if (cfg_we) begin
			pc_q    <= cfg_wdata;
			load_q  <= '0;
			total_q <= '0;
		end else if (q_push) begin
			load_q  <= '0;
			total_q <= '0;
		end else if (do_load) begin
			load_q  <= load_q + CNT_W'(1);
			total_q <= total_q + SUM_W'(w);
		end
	end

endmodule

// File: src/srs_cmd_queue.sv
// Two-entry queue of resampling runs between front and back end.
`timescale 1ns / 1ps
module srs_cmd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	import srs_pkg::*;

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign empty   = (count_q == 2'd0);
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && (count_q != 2'd2);
	assign do_pop  = pop && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/srs_back.sv
// Back end: weight memory and the cursor/point walk that emits indices.
`timescale 1ns / 1ps
module srs_back #(
	parameter int MAX_PARTICLES = 64,
	parameter int WEIGHT_BITS   = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               cmd_valid,
	input  logic [16+WEIGHT_BITS+$clog2(MAX_PARTICLES)+2*$clog2(MAX_PARTICLES+1)-1:0] cmd_data,
	output logic                                               cmd_pop,
	input  logic                                               mem_we,
	input  logic [$clog2(MAX_PARTICLES)-1:0]                   mem_addr,
	input  logic [WEIGHT_BITS+$clog2(MAX_PARTICLES+1)-1:0]     mem_wdata,
	output logic                                               busy,
	input  logic                                               pop,
	output logic                                               empty,
	output srs_pkg::out_res_t                                  result
);
	import srs_pkg::*;

	localparam int IDX_W  = $clog2(MAX_PARTICLES);
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
	localparam int SUM_W  = WEIGHT_BITS + IDX_W;
	localparam int NW_W   = WEIGHT_BITS + CNT_W;
	localparam int PROD_W = SUM_W + 16 + CNT_W;
	localparam int MUL_W  = SUM_W + 16;

	// weight memory, entries hold n * weight
	logic [NW_W-1:0]   mem [MAX_PARTICLES];
	logic [NW_W-1:0]   rd_q;
	logic [IDX_W-1:0]  rd_addr;

	// run registers
	back_state_t       state_q, state_d;
	logic [15:0]       offset_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  n_q;
	logic              zero_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [CNT_W-1:0]  j_q;
	logic [PROD_W-1:0] point_q;
	logic [PROD_W-1:0] rhs_q;

	// result register
	out_res_t          out_q;
	logic              out_v_q;

	// decoded command
	logic [15:0]       cmd_offset;
	logic [SUM_W-1:0]  cmd_sum;
	logic [CNT_W-1:0]  cmd_loaded;
	logic [CNT_W-1:0]  cmd_n;

	// control
	logic              take;
	logic              seed;
	logic              adv;
	logic              emit;
	logic              is_last;
	logic              slot_free;
	logic [NW_W-1:0]   seed_w;
	logic [NW_W-1:0]   next_w;
	logic [MUL_W-1:0]  start_prod;

	assign {cmd_offset, cmd_sum, cmd_loaded, cmd_n} = cmd_data;

	assign busy      = (state_q != BK_IDLE);
	assign slot_free = !out_v_q || pop;
	assign is_last   = ((j_q + CNT_W'(1)) == n_q);
	assign empty     = !out_v_q;
	assign result    = out_q;
	assign cmd_pop   = take;

	// entries at or above the loaded count read as zero
	assign seed_w = (loaded_q != '0) ? rd_q : '0;
	assign next_w = ((CNT_W'(cursor_q) + CNT_W'(1)) < loaded_q) ? rd_q : '0;

	assign start_prod = MUL_W'(offset_q) * MUL_W'(sum_q);

	// memory: one write port from the front end, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer: next state and step controls
	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		seed    = 1'b0;
		adv     = 1'b0;
		emit    = 1'b0;
		rd_addr = cursor_q + IDX_W'(1);
		case (state_q)
			BK_IDLE: begin
				rd_addr = '0;
				if (cmd_valid) begin
					take    = 1'b1;
					state_d = BK_SEED;
				end
			end
			BK_SEED: begin
				rd_addr = IDX_W'(1);
				seed    = 1'b1;
				state_d = BK_WALK;
			end
			BK_WALK: begin
				// advance the cursor while the point lies past the cumulative weight
				adv = !zero_q && ((CNT_W'(cursor_q) + CNT_W'(1)) < n_q) && (point_q > rhs_q);
				if (adv) begin
					rd_addr = cursor_q + IDX_W'(2);
				end else if (slot_free) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// run datapath
	always_ff @(posedge clk) begin
		if (take) begin
			offset_q <= cmd_offset;
			sum_q    <= cmd_sum;
			loaded_q <= cmd_loaded;
			n_q      <= cmd_n;
			zero_q   <= (cmd_sum == '0);
			cursor_q <= '0;
			j_q      <= '0;
		end
		if (seed) begin
			point_q <= PROD_W'(start_prod);
			rhs_q   <= PROD_W'(seed_w) << 16;
		end
		if (adv) begin
			cursor_q <= cursor_q + IDX_W'(1);
			rhs_q    <= rhs_q + (PROD_W'(next_w) << 16);
		end
		if (emit) begin
			j_q     <= j_q + CNT_W'(1);
			point_q <= point_q + (PROD_W'(sum_q) << 16);
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.index    <= zero_q ? 6'(j_q[IDX_W-1:0]) : 6'(cursor_q);
			out_q.last     <= is_last;
			out_q.zero_sum <= zero_q;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

endmodule
